FILE: sv/wfg_pkg.sv
package wfg_pkg;

    // default sizes of the process and resource index spaces
    localparam int NUM_PROCS_DEF = 16;
    localparam int NUM_RES_DEF   = 16;

    // field widths of the words on the ports
    localparam int REQ_W   = 2;
    localparam int ID_W    = 4;
    localparam int COUNT_W = 9;

    // request codes
    localparam logic [REQ_W-1:0] REQ_ASSIGN = 2'd0;
    localparam logic [REQ_W-1:0] REQ_WAIT   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_EVAL   = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [ID_W-1:0]  process_id;
        logic [ID_W-1:0]  resource_id;
    } t_in_word;

    typedef struct packed {
        logic               deadlock;
        logic [COUNT_W-1:0] edge_count;
    } t_out_word;

endpackage

FILE: sv/wfg_ram.sv
module wfg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write one entry, register the read word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/wait_for_graph_deadlock_detect.sv
// Assign item: the owner table is written on acceptance. Wait item: read, then write
// back its wait row. Evaluate: accept, build walk, up to NUM_PROCS+1 peel passes over
// all processes, then a result step (held while a word waits). The build walk reads
// one owner-table entry and a peel pass one edge row per cycle; one word at a time.
// Synchronous active-low reset marks all resources unowned and all wait rows empty
// through flag registers; no clearing pass is run, the block is ready at once.
module wait_for_graph_deadlock_detect #(
    parameter int NUM_PROCS = wfg_pkg::NUM_PROCS_DEF,
    parameter int NUM_RES   = wfg_pkg::NUM_RES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  wfg_pkg::t_in_word i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output wfg_pkg::t_out_word o_out_word
);

    localparam int PW = $clog2(NUM_PROCS);
    localparam int RW = (NUM_RES > 1) ? $clog2(NUM_RES) : 1;
    localparam int CW = $clog2(NUM_PROCS * NUM_PROCS);
    localparam int OW = wfg_pkg::COUNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRD,
        S_BROW,
        S_BSCAN,
        S_PADDR,
        S_PSCAN,
        S_RES
    } t_state;

    t_state r_state, n_state;

    logic [NUM_RES-1:0]   r_own_vld, n_own_vld;
    logic [NUM_PROCS-1:0] r_wrow_vld, n_wrow_vld;
    logic [NUM_PROCS-1:0] r_erow, n_erow;
    logic [NUM_PROCS-1:0] r_alive, n_alive;
    logic [PW-1:0]        r_pidx, n_pidx;
    logic [RW-1:0]        r_ridx, n_ridx;
    logic [CW-1:0]        r_count, n_count;
    logic                 r_chg, n_chg;
    logic [PW-1:0]        r_wpid, n_wpid;
    logic [RW-1:0]        r_wres, n_wres;
    logic                 r_out_valid, n_out_valid;
    wfg_pkg::t_out_word   r_out_word, n_out_word;

    // RAM ports
    logic           own_we, own_re;
    logic [RW-1:0]  own_waddr, own_raddr;
    logic [PW-1:0]  own_wdata, own_rdata;
    logic           wait_we, wait_re;
    logic [PW-1:0]  wait_waddr, wait_raddr;
    logic [NUM_RES-1:0] wait_wdata, wait_rdata;
    logic           edge_we, edge_re;
    logic [PW-1:0]  edge_waddr, edge_raddr;
    logic [NUM_PROCS-1:0] edge_wdata, edge_rdata;

    logic           in_acc, out_acc;
    logic           pid_ok, rid_ok;
    logic [PW+wfg_pkg::ID_W-1:0] pid_ext;
    logic [RW+wfg_pkg::ID_W-1:0] rid_ext;
    logic [PW-1:0]  in_pid;
    logic [RW-1:0]  in_rid;
    logic           hit, new_bit, can_peel, chg_now;
    logic [CW+OW-1:0] count_ext;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = r_out_valid && i_out_ready;

    // narrow or widen incoming indices to the table address widths
    assign pid_ok  = 32'(i_in_word.process_id) < NUM_PROCS;
    assign rid_ok  = 32'(i_in_word.resource_id) < NUM_RES;
    assign pid_ext = (PW + wfg_pkg::ID_W)'(i_in_word.process_id);
    assign rid_ext = (RW + wfg_pkg::ID_W)'(i_in_word.resource_id);
    assign in_pid  = pid_ext[PW-1:0];
    assign in_rid  = rid_ext[RW-1:0];

    // edge found for wait (r_pidx, r_ridx) during the build walk
    assign hit = r_wrow_vld[r_pidx] && wait_rdata[r_ridx] && r_own_vld[r_ridx]
                 && (own_rdata != r_pidx);
    assign new_bit = hit && !r_erow[own_rdata];

    // node with no live successor may be peeled off
    assign can_peel = r_alive[r_pidx] && ((edge_rdata & r_alive) == '0);
    assign chg_now  = r_chg || can_peel;

    assign count_ext = (CW + OW)'(r_count);

    // sequencer next-state and RAM control
    always_comb begin
        n_state     = r_state;
        n_own_vld   = r_own_vld;
        n_wrow_vld  = r_wrow_vld;
        n_erow      = r_erow;
        n_alive     = r_alive;
        n_pidx      = r_pidx;
        n_ridx      = r_ridx;
        n_count     = r_count;
        n_chg       = r_chg;
        n_wpid      = r_wpid;
        n_wres      = r_wres;
        n_out_valid = r_out_valid && !out_acc;
        n_out_word  = r_out_word;

        own_we     = 1'b0;
        own_waddr  = in_rid;
        own_wdata  = in_pid;
        own_re     = 1'b0;
        own_raddr  = '0;
        wait_we    = 1'b0;
        wait_waddr = r_wpid;
        wait_wdata = (r_wrow_vld[r_wpid] ? wait_rdata : '0) | (NUM_RES'(1) << r_wres);
        wait_re    = 1'b0;
        wait_raddr = r_pidx;
        edge_we    = 1'b0;
        edge_waddr = r_pidx;
        edge_wdata = r_erow;
        edge_re    = 1'b0;
        edge_raddr = r_pidx;

        case (r_state)
            S_IDLE: begin
                wait_raddr = in_pid;
                if (in_acc) begin
                    case (i_in_word.req_type)
                        wfg_pkg::REQ_ASSIGN: begin
                            if (pid_ok && rid_ok) begin
                                own_we            = 1'b1;
                                n_own_vld[in_rid] = 1'b1;
                            end
                        end
                        wfg_pkg::REQ_WAIT: begin
                            if (pid_ok && rid_ok) begin
                                wait_re = 1'b1;
                                n_wpid  = in_pid;
                                n_wres  = in_rid;
                                n_state = S_WRD;
                            end
                        end
                        wfg_pkg::REQ_EVAL: begin
                            n_pidx  = '0;
                            n_count = '0;
                            n_erow  = '0;
                            n_state = S_BROW;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WRD: begin
                // write back the wait row with the new bit set
                wait_we               = 1'b1;
                n_wrow_vld[r_wpid]    = 1'b1;
                n_state               = S_IDLE;
            end
            S_BROW: begin
                wait_re   = 1'b1;
                own_re    = 1'b1;
                own_raddr = '0;
                n_ridx    = '0;
                n_state   = S_BSCAN;
            end
            S_BSCAN: begin
                own_re    = 1'b1;
                own_raddr = r_ridx + RW'(1);
                if (hit) begin
                    n_erow = r_erow | (NUM_PROCS'(1) << own_rdata);
                end
                n_count = r_count + CW'(new_bit);
                n_ridx  = r_ridx + RW'(1);
                if (r_ridx == RW'(NUM_RES - 1)) begin
                    edge_we    = 1'b1;
                    edge_wdata = n_erow;
                    n_erow     = '0;
                    if (r_pidx == PW'(NUM_PROCS - 1)) begin
                        n_pidx  = '0;
                        n_alive = '1;
                        n_state = S_PADDR;
                    end else begin
                        n_pidx  = r_pidx + PW'(1);
                        n_state = S_BROW;
                    end
                end
            end
            S_PADDR: begin
                edge_re    = 1'b1;
                edge_raddr = r_pidx;
                n_chg      = 1'b0;
                n_state    = S_PSCAN;
            end
            S_PSCAN: begin
                edge_re    = 1'b1;
                edge_raddr = r_pidx + PW'(1);
                if (can_peel) begin
                    n_alive[r_pidx] = 1'b0;
                end
                n_chg  = chg_now;
                n_pidx = r_pidx + PW'(1);
                if (r_pidx == PW'(NUM_PROCS - 1)) begin
                    n_pidx = '0;
                    if (chg_now) begin
                        n_state = S_PADDR;
                    end else begin
                        n_state = S_RES;
                    end
                end
            end
            S_RES: begin
                // hand over the result word once the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid           = 1'b1;
                    n_out_word.deadlock   = |r_alive;
                    n_out_word.edge_count = count_ext[OW-1:0];
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_own_vld   <= '0;
            r_wrow_vld  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_own_vld   <= n_own_vld;
            r_wrow_vld  <= n_wrow_vld;
            r_out_valid <= n_out_valid;
        end
        r_erow     <= n_erow;
        r_alive    <= n_alive;
        r_pidx     <= n_pidx;
        r_ridx     <= n_ridx;
        r_count    <= n_count;
        r_chg      <= n_chg;
        r_wpid     <= n_wpid;
        r_wres     <= n_wres;
        r_out_word <= n_out_word;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // owner of each resource
    wfg_ram #(
        .WIDTH (PW),
        .DEPTH (NUM_RES)
    ) u_owner (
        .i_clk   (i_clk),
        .i_we    (own_we),
        .i_waddr (own_waddr),
        .i_wdata (own_wdata),
        .i_re    (own_re),
        .i_raddr (own_raddr),
        .o_rdata (own_rdata)
    );

    // resources each process waits on
    wfg_ram #(
        .WIDTH (NUM_RES),
        .DEPTH (NUM_PROCS)
    ) u_wait (
        .i_clk   (i_clk),
        .i_we    (wait_we),
        .i_waddr (wait_waddr),
        .i_wdata (wait_wdata),
        .i_re    (wait_re),
        .i_raddr (wait_raddr),
        .o_rdata (wait_rdata)
    );

    // wait-for edge rows
    wfg_ram #(
        .WIDTH (NUM_PROCS),
        .DEPTH (NUM_PROCS)
    ) u_edge (
        .i_clk   (i_clk),
        .i_we    (edge_we),
        .i_waddr (edge_waddr),
        .i_wdata (edge_wdata),
        .i_re    (edge_re),
        .i_raddr (edge_raddr),
        .o_rdata (edge_rdata)
    );

    // a result word only ever follows the hand-over step
    a_out_from_peel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_RES))
        else $error("result word raised outside the hand-over step");

    // an evaluate word always starts the build walk
    a_eval_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_word.req_type == wfg_pkg::REQ_EVAL) |=> (r_state == S_BROW))
        else $error("evaluate word did not start the build walk");

    // a peeled node never comes back to life
    a_alive_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PSCAN) |=> ((r_alive & ~$past(r_alive)) == '0))
        else $error("peeled node revived");

    // edge count stays within a graph without self loops
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PADDR) |-> (r_count <= CW'(NUM_PROCS * (NUM_PROCS - 1))))
        else $error("edge count beyond the number of possible edges");

endmodule
